// ===== rtl/core/model_header_byte_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the header byte parser
// Clocked property checks on clk_i, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef MODEL_HEADER_BYTE_PARSER_ASSERT_SVH
`define MODEL_HEADER_BYTE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property check that is switched off while rst_ni is low.
`define MHBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Property check that also holds while reset is applied.
`define MHBP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MHBP_ASSERT(label, prop, msg)
`define MHBP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/mhbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mhbp_pkg
// Types, codes and constants shared by the header byte parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mhbp_pkg;

  // Input transaction: one byte of the header buffer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  // Output transaction: one parser result.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] header_flags;
    logic [31:0] tensor_count;
    logic [1:0]  error_code;
    logic        run_last;
  } out_item_t;

  // Result kinds.
  localparam logic [1:0] KIND_NAME     = 2'd0;
  localparam logic [1:0] KIND_CONFIG   = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MAGIC     = 2'd1;
  localparam logic [1:0] ERR_VERSION   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Prefix layout: magic bytes 0..3, version 4..7, flags 8..11.
  localparam int unsigned BC_W = 4;
  localparam logic [BC_W-1:0] MAGIC_LEN        = 4'd4;
  localparam logic [BC_W-1:0] VERSION_LAST_IDX = 4'd7;
  localparam logic [BC_W-1:0] PREFIX_LAST_IDX  = 4'd11;
  localparam logic [BC_W-1:0] NAMELEN_BYTES    = 4'd2;
  localparam logic [BC_W-1:0] WORD_BYTES       = 4'd4;

  typedef enum logic [6:0] {
    PH_PREFIX  = 7'b000_0001,
    PH_NAMELEN = 7'b000_0010,
    PH_NAME    = 7'b000_0100,
    PH_CFGLEN  = 7'b000_1000,
    PH_CFG     = 7'b001_0000,
    PH_COUNT   = 7'b010_0000,
    PH_DRAIN   = 7'b100_0000
  } phase_e;

  // Up to two results per accepted byte.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

  // Output queue.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;
  localparam logic [FIFO_CW-1:0] FIFO_STALL_LEVEL = FIFO_CW'(FIFO_DEPTH - 2);
  localparam logic [FIFO_CW-1:0] FIFO_FULL_COUNT  = FIFO_CW'(FIFO_DEPTH);

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               stall;
  } fifo_stat_t;

  // Register map: index taken from paddr[2].
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic [31:0] EXPECTED_VERSION_RST = 32'd1;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0: val = 8'h47;
      2'd1: val = 8'h53;
      2'd2: val = 8'h56;
      default: val = 8'h31;
    endcase
    return val;
  endfunction

  function automatic out_item_t error_item(input logic [1:0] code);
    out_item_t it;
    it = '0;
    it.kind = KIND_ERROR;
    it.error_code = code;
    return it;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mhbp_cfg.sv =====
// ----------------------------------------------------------------------------
// mhbp_cfg
// APB register slave holding the expected format version.
// ----------------------------------------------------------------------------
`default_nettype none

module mhbp_cfg import mhbp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic [31:0]             expected_version_o
);

  logic [31:0] exp_ver_q, exp_ver_d;
  logic        wr_en;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_EXPECTED_VERSION);
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;

  always_comb begin
    exp_ver_d = exp_ver_q;
    if (wr_en) begin
      exp_ver_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= EXPECTED_VERSION_RST;
    end else begin
      exp_ver_q <= exp_ver_d;
    end
  end

  assign prdata = reg_hit ? exp_ver_q : 32'd0;
  assign expected_version_o = exp_ver_q;

endmodule

`default_nettype wire

// ===== rtl/core/mhbp_parser.sv =====
// ----------------------------------------------------------------------------
// mhbp_parser
// Header state machine: consumes one byte per transaction and produces up
// to two results for it in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mhbp_parser import mhbp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire in_item_t    item_i,
  input  wire logic [31:0] expected_version_i,
  output res_pair_t        res_o
);

  phase_e          phase_q, phase_d;
  logic [BC_W-1:0] bc_q, bc_d, bc_inc, need;
  logic [31:0]     fl_q, fl_d, fl_dec;
  logic [31:0]     acc_q, acc_d, acc_new, acc_p;
  logic [31:0]     flags_q, flags_d;
  logic            vm_q, vm_d, vm_p;
  logic            do_finish, do_restart;
  logic [7:0]      b;
  logic            last;
  res_pair_t       res;

  assign b    = item_i.data_byte;
  assign last = item_i.end_of_buffer;

  assign acc_new = acc_q | ({24'd0, b} << {bc_q[1:0], 3'b000});
  assign bc_inc  = bc_q + 4'd1;
  assign fl_dec  = (fl_q != 32'd0) ? fl_q - 32'd1 : 32'd0;
  assign need    = (phase_q == PH_NAMELEN) ? NAMELEN_BYTES : WORD_BYTES;

  always_comb begin
    phase_d    = phase_q;
    bc_d       = bc_q;
    fl_d       = fl_q;
    acc_d      = acc_q;
    flags_d    = flags_q;
    vm_d       = vm_q;
    do_finish  = 1'b0;
    do_restart = 1'b0;
    res        = '0;
    acc_p      = (bc_q < MAGIC_LEN) ? acc_q : acc_new;
    vm_p       = vm_q;
    // The version compare includes the byte that completes the word.
    if (bc_q == VERSION_LAST_IDX) begin
      vm_p  = (acc_p == expected_version_i);
      acc_p = '0;
    end

    case (phase_q)
      PH_PREFIX: begin
        if ((bc_q < MAGIC_LEN) && (b != magic_byte(bc_q[1:0]))) begin
          res.cnt   = 2'd1;
          res.r0    = error_item(ERR_MAGIC);
          do_finish = 1'b1;
        end else if (bc_q >= PREFIX_LAST_IDX) begin
          if (!vm_p) begin
            res.cnt   = 2'd1;
            res.r0    = error_item(ERR_VERSION);
            do_finish = 1'b1;
          end else if (last) begin
            res.cnt    = 2'd1;
            res.r0     = error_item(ERR_TRUNCATED);
            do_restart = 1'b1;
          end else begin
            flags_d = acc_p;
            acc_d   = '0;
            bc_d    = '0;
            phase_d = PH_NAMELEN;
          end
        end else if (last) begin
          res.cnt    = 2'd1;
          res.r0     = error_item(ERR_MAGIC);
          do_restart = 1'b1;
        end else begin
          bc_d  = bc_inc;
          acc_d = acc_p;
          vm_d  = vm_p;
        end
      end
      PH_NAMELEN, PH_CFGLEN, PH_COUNT: begin
        if (bc_inc < need) begin
          if (last) begin
            res.cnt    = 2'd1;
            res.r0     = error_item(ERR_TRUNCATED);
            do_restart = 1'b1;
          end else begin
            acc_d = acc_new;
            bc_d  = bc_inc;
          end
        end else if (phase_q == PH_COUNT) begin
          res.cnt             = 2'd1;
          res.r0.kind         = KIND_COMPLETE;
          res.r0.header_flags = flags_q;
          res.r0.tensor_count = acc_new;
          do_finish           = 1'b1;
        end else if (last) begin
          res.cnt    = 2'd1;
          res.r0     = error_item(ERR_TRUNCATED);
          do_restart = 1'b1;
        end else begin
          fl_d  = acc_new;
          acc_d = '0;
          bc_d  = '0;
          // A zero length skips the byte field entirely.
          if (phase_q == PH_NAMELEN) begin
            phase_d = (acc_new == 32'd0) ? PH_CFGLEN : PH_NAME;
          end else begin
            phase_d = (acc_new == 32'd0) ? PH_COUNT : PH_CFG;
          end
        end
      end
      PH_NAME, PH_CFG: begin
        res.cnt           = 2'd1;
        res.r0.kind       = (phase_q == PH_NAME) ? KIND_NAME : KIND_CONFIG;
        res.r0.byte_value = b;
        fl_d              = fl_dec;
        if (last) begin
          // The byte still passes through ahead of the truncation error.
          res.cnt    = 2'd2;
          res.r1     = error_item(ERR_TRUNCATED);
          do_restart = 1'b1;
        end else if (fl_dec == 32'd0) begin
          phase_d = (phase_q == PH_NAME) ? PH_CFGLEN : PH_COUNT;
          bc_d    = '0;
          acc_d   = '0;
        end
      end
      default: begin
        if (last) begin
          do_restart = 1'b1;
        end
      end
    endcase

    if (do_restart || (do_finish && last)) begin
      phase_d = PH_PREFIX;
      bc_d    = '0;
      fl_d    = '0;
      acc_d   = '0;
      flags_d = '0;
      vm_d    = 1'b0;
    end else if (do_finish) begin
      phase_d = PH_DRAIN;
    end

    res.r0.run_last = (res.cnt == 2'd1);
    res.r1.run_last = (res.cnt == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      bc_q    <= '0;
      fl_q    <= '0;
      acc_q   <= '0;
      flags_q <= '0;
      vm_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      fl_q    <= fl_d;
      acc_q   <= acc_d;
      flags_q <= flags_d;
      vm_q    <= vm_d;
    end
  end

  always_comb begin
    res_o = res;
    if (!accept_i) begin
      res_o.cnt = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mhbp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// mhbp_out_fifo
// Four-entry result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module mhbp_out_fifo import mhbp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire res_pair_t push_i,
  input  wire logic      pop_i,
  output logic           valid_o,
  output out_item_t      item_o,
  output fifo_stat_t     stat_o
);

  out_item_t          entries_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, wr_d, wr_nxt;
  logic [FIFO_AW-1:0] rd_q, rd_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  assign wr_nxt = wr_q + FIFO_AW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entries_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      entries_q[wr_nxt] <= push_i.r1;
    end
  end

  always_comb begin
    wr_d  = wr_q + FIFO_AW'(push_i.cnt);
    rd_d  = rd_q + FIFO_AW'(pop_i);
    cnt_d = cnt_q + FIFO_CW'(push_i.cnt) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o      = (cnt_q != '0);
  assign item_o       = entries_q[rd_q];
  // Room for two results must exist before the next byte is taken.
  assign stat_o.count = cnt_q;
  assign stat_o.stall = (cnt_q > FIFO_STALL_LEVEL);

endmodule

`default_nettype wire

// ===== rtl/core/model_header_byte_parser.sv =====
// ----------------------------------------------------------------------------
// model_header_byte_parser
// Streaming parser for a model file header with name and config pass-through.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one header byte per transaction with a flag on
// the last byte of the buffer. The output channel carries results: name
// bytes, config text bytes, a header-complete record with flags and tensor
// count, or an error record. One byte yields zero, one or two results; the
// last result of a byte has run_last set.
// A byte is parsed in the cycle it is accepted and its results are
// registered into a four-entry queue and offered from it in order. One
// byte can be accepted every cycle while the queue has room for two
// results; it is drained at one result per cycle while out_stall_i is low.
// in_stall_o rises when the queue holds more than two results, which
// happens only when the receiver stalls or a byte yields two results.
// Reset empties the queue, returns the parser to the magic check and sets
// expected_version to 1. The user writes the register through the APB port
// only while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module model_header_byte_parser import mhbp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic        in_accept;
  logic        out_pop;
  logic [31:0] expected_version;
  res_pair_t   res;
  fifo_stat_t  fifo_stat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_pop   = out_valid_o && !out_stall_i;
  assign in_stall_o = fifo_stat.stall;

  mhbp_cfg u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .expected_version_o (expected_version)
  );

  mhbp_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .item_i             (in_data_i),
    .expected_version_i (expected_version),
    .res_o              (res)
  );

  mhbp_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .item_o  (out_data_o),
    .stat_o  (fifo_stat)
  );

`include "model_header_byte_parser_assert.svh"

  `MHBP_ASSERT(a_fifo_bound, fifo_stat.count <= FIFO_FULL_COUNT, "result queue overflow")
  `MHBP_ASSERT(a_result_shown, (in_accept && (res.cnt != 2'd0)) |=> out_valid_o, "result lost")
  `MHBP_ASSERT(a_err_code, (out_valid_o && (out_data_o.kind == KIND_ERROR)) |-> (out_data_o.error_code != ERR_NONE), "error result without code")
  `MHBP_ASSERT(a_no_pop_empty, (fifo_stat.count == '0) |-> !out_valid_o, "valid on empty queue")

endmodule

`default_nettype wire
